// ===== sv/mu8d_pkg.sv =====
// Types and constants shared by the modified UTF-8 string decoder modules.
package mu8d_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);
    localparam int FifoCw    = $clog2(FifoDepth + 1);

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CONT = 2'd1;
    localparam logic [1:0] ST_BAD_LEAD = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // Framing state of the front end.
    typedef enum logic [1:0] {
        FR_LEN_HI,
        FR_LEN_LO,
        FR_BODY
    } front_state_t;

    // Decoding state of the back end.
    typedef enum logic [1:0] {
        BK_LEAD,
        BK_CONT1,
        BK_CONT2,
        BK_SKIP
    } back_state_t;

    // One classified item passed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       last;   // final body byte of the string
        logic       lt2;    // fewer than two body bytes follow this one
        logic       empty;  // stands for a zero-length string, data unused
    } item_t;

endpackage

// ===== sv/mu8d_front.sv =====
// Front end: parses the length header, tags each body byte with its framing and marks zero-length strings.
module mu8d_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    output logic            in_ready,
    input  logic            push_ready,
    output logic            push_valid,
    output mu8d_pkg::item_t push_item
);

    mu8d_pkg::front_state_t phase_reg, phase_next;
    logic [7:0]             length_high_reg, length_high_next;
    logic [15:0]            bytes_left_reg, bytes_left_next;
    logic                   accept;
    logic [15:0]            length_full;
    logic [15:0]            left_after;

    assign in_ready    = push_ready;
    assign accept      = in_valid && push_ready;
    assign length_full = {length_high_reg, in_byte};
    assign left_after  = bytes_left_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= mu8d_pkg::FR_LEN_HI;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
        end else begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        bytes_left_next  = bytes_left_reg;
        if (accept) begin
            unique case (phase_reg)
                mu8d_pkg::FR_LEN_HI: begin
                    length_high_next = in_byte;
                    phase_next       = mu8d_pkg::FR_LEN_LO;
                end
                mu8d_pkg::FR_LEN_LO: begin
                    bytes_left_next = length_full;
                    phase_next      = (length_full == 16'd0) ? mu8d_pkg::FR_LEN_HI
                                                             : mu8d_pkg::FR_BODY;
                end
                mu8d_pkg::FR_BODY: begin
                    bytes_left_next = left_after;
                    if (left_after == 16'd0) begin
                        phase_next = mu8d_pkg::FR_LEN_HI;
                    end
                end
                default: phase_next = mu8d_pkg::FR_LEN_HI;
            endcase
        end
    end

    always_comb begin
        push_valid      = 1'b0;
        push_item.data  = in_byte;
        push_item.last  = 1'b1;
        push_item.lt2   = 1'b1;
        push_item.empty = 1'b0;
        unique case (phase_reg)
            mu8d_pkg::FR_LEN_LO: begin
                // Only a zero length yields an item: the empty-string marker.
                push_valid      = accept && (length_full == 16'd0);
                push_item.empty = 1'b1;
            end
            mu8d_pkg::FR_BODY: begin
                push_valid     = accept;
                push_item.last = (left_after == 16'd0);
                push_item.lt2  = (bytes_left_reg <= 16'd2);
            end
            default: push_valid = 1'b0;
        endcase
    end

endmodule

// ===== sv/mu8d_fifo.sv =====
// Short queue that decouples the front end from the back end.
module mu8d_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    input  mu8d_pkg::item_t wr_item,
    output logic            wr_ready,
    output logic            rd_valid,
    output mu8d_pkg::item_t rd_item,
    input  logic            rd_take
);

    mu8d_pkg::item_t                   mem [mu8d_pkg::FifoDepth];
    logic [mu8d_pkg::FifoAw-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mu8d_pkg::FifoAw-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mu8d_pkg::FifoCw-1:0]       count_reg, count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign wr_ready = (count_reg != mu8d_pkg::FifoCw'(mu8d_pkg::FifoDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== sv/mu8d_back.sv =====
// Back end: assembles code units from body bytes and holds the result register.
module mu8d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_valid,
    input  mu8d_pkg::item_t item,
    output logic            item_take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_code_unit,
    output logic [1:0]      m_status,
    output logic            m_last_of_string,
    output logic            m_empty_string
);

    mu8d_pkg::back_state_t state_reg, state_next;
    logic [15:0]           partial_reg, partial_next;
    logic                  m_valid_reg, m_valid_next;
    logic [15:0]           code_reg;
    logic [1:0]            status_reg;
    logic                  last_reg;
    logic                  empty_reg;

    // Result produced by the item taken in this cycle.
    logic                  res_valid;
    logic [15:0]           res_code;
    logic [1:0]            res_status;
    logic                  res_last;
    logic                  res_empty;
    logic                  cont_ok;

    assign item_take = item_valid && (!m_valid_reg || m_ready);
    assign cont_ok   = (item.data[7:6] == 2'b10);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mu8d_pkg::BK_LEAD;
            partial_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next   = state_reg;
        partial_next = partial_reg;
        if (item_take && !item.empty) begin
            unique case (state_reg)
                mu8d_pkg::BK_LEAD: begin
                    if (!item.data[7]) begin
                        state_next = mu8d_pkg::BK_LEAD;
                    end else if (item.data[7:5] == 3'b110) begin
                        partial_next = {5'd0, item.data[4:0], 6'd0};
                        state_next   = item.last ? mu8d_pkg::BK_LEAD : mu8d_pkg::BK_CONT1;
                    end else if (item.data[7:4] == 4'b1110) begin
                        partial_next = {item.data[3:0], 12'd0};
                        state_next   = item.lt2
                                       ? (item.last ? mu8d_pkg::BK_LEAD : mu8d_pkg::BK_SKIP)
                                       : mu8d_pkg::BK_CONT2;
                    end else begin
                        state_next = item.last ? mu8d_pkg::BK_LEAD : mu8d_pkg::BK_SKIP;
                    end
                end
                mu8d_pkg::BK_CONT2: begin
                    if (cont_ok) begin
                        partial_next = partial_reg | {4'd0, item.data[5:0], 6'd0};
                        state_next   = mu8d_pkg::BK_CONT1;
                    end else begin
                        state_next = item.last ? mu8d_pkg::BK_LEAD : mu8d_pkg::BK_SKIP;
                    end
                end
                mu8d_pkg::BK_CONT1: begin
                    if (cont_ok) begin
                        state_next = mu8d_pkg::BK_LEAD;
                    end else begin
                        state_next = item.last ? mu8d_pkg::BK_LEAD : mu8d_pkg::BK_SKIP;
                    end
                end
                mu8d_pkg::BK_SKIP: begin
                    if (item.last) begin
                        state_next = mu8d_pkg::BK_LEAD;
                    end
                end
                default: state_next = mu8d_pkg::BK_LEAD;
            endcase
        end else if (item_take) begin
            state_next = mu8d_pkg::BK_LEAD;
        end
    end

    // Result logic for the item being taken.
    always_comb begin
        res_valid  = 1'b0;
        res_code   = 16'd0;
        res_status = mu8d_pkg::ST_OK;
        res_last   = 1'b1;
        res_empty  = 1'b0;
        if (item.empty) begin
            res_valid = 1'b1;
            res_empty = 1'b1;
        end else begin
            unique case (state_reg)
                mu8d_pkg::BK_LEAD: begin
                    if (!item.data[7]) begin
                        res_valid = 1'b1;
                        res_code  = {8'd0, item.data};
                        res_last  = item.last;
                    end else if (item.data[7:5] == 3'b110) begin
                        res_valid  = item.last;
                        res_status = mu8d_pkg::ST_TRUNC;
                    end else if (item.data[7:4] == 4'b1110) begin
                        res_valid  = item.lt2;
                        res_status = mu8d_pkg::ST_TRUNC;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = mu8d_pkg::ST_BAD_LEAD;
                    end
                end
                mu8d_pkg::BK_CONT2: begin
                    res_valid  = !cont_ok;
                    res_status = mu8d_pkg::ST_BAD_CONT;
                end
                mu8d_pkg::BK_CONT1: begin
                    res_valid = 1'b1;
                    if (cont_ok) begin
                        res_code = partial_reg | {10'd0, item.data[5:0]};
                        res_last = item.last;
                    end else begin
                        res_status = mu8d_pkg::ST_BAD_CONT;
                    end
                end
                mu8d_pkg::BK_SKIP: res_valid = 1'b0;
                default:           res_valid = 1'b0;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (item_take && res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && res_valid) begin
            code_reg   <= res_code;
            status_reg <= res_status;
            last_reg   <= res_last;
            empty_reg  <= res_empty;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_code_unit      = code_reg;
    assign m_status         = status_reg;
    assign m_last_of_string = last_reg;
    assign m_empty_string   = empty_reg;

endmodule

// ===== sv/modified_utf8_string_decoder.sv =====
// Top level of the modified UTF-8 string decoder: front end, queue and back end.
// Throughput: one byte per cycle while the queue is not full, set by the framing update in the front end.
// m_valid rises after the byte that completes a result has passed the queue and the back end's result register.
// A four-entry queue lets the header parser keep taking bytes while results stall, until the queue fills.
// Reset (aresetn low at a clock edge) empties the queue, returns the front end to
// waiting for the high byte of a length header and the back end to waiting for a lead byte.
module modified_utf8_string_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic [1:0]  m_status,
    output logic        m_last_of_string,
    output logic        m_empty_string
);

    logic            push_valid;
    logic            push_ready;
    mu8d_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_take;
    mu8d_pkg::item_t pop_item;

    mu8d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_byte    (s_in_byte),
        .in_ready   (s_ready),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    mu8d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_item  (push_item),
        .wr_ready (push_ready),
        .rd_valid (pop_valid),
        .rd_item  (pop_item),
        .rd_take  (pop_take)
    );

    mu8d_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_valid       (pop_valid),
        .item             (pop_item),
        .item_take        (pop_take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_unit      (m_code_unit),
        .m_status         (m_status),
        .m_last_of_string (m_last_of_string),
        .m_empty_string   (m_empty_string)
    );

endmodule
